@@ sv/mhed_pkg.sv @@
// Package: types and constants for the LoG zero-crossing edge detector.
`timescale 1ns / 1ps
`default_nettype none
package mhed_pkg;
	localparam int Win = 9;
	localparam int Rad = 4;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 13;
	localparam logic [CfgIdxW-1:0] REG_WIDTH = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'd1;
	localparam logic [11:0] WIDTH_RESET = 12'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam int MaxHeight = 4096;
	localparam int ProdW = 33;
	localparam int SumW = 40;

	typedef enum logic [1:0] {
		SIGN_ZERO = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} sign_t;

	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_DRAIN = 1'b1
	} action_t;

	// LoG * 2^24, indexed by |row offset| and |column offset|
	function automatic logic signed [31:0] log_q24(input int dr, input int dc);
		logic signed [31:0] t [0:24];
		t = '{-32'sd6553600, -32'sd4337945, -32'sd656350, 32'sd856315, 32'sd611883,
			-32'sd4337945, -32'sd2702205, -32'sd57846, 32'sd885928, 32'sd549582,
			-32'sd656350, -32'sd57846, 32'sd772711, 32'sd796224, 32'sd383133,
			32'sd856315, 32'sd885928, 32'sd796224, 32'sd490128, 32'sd192774,
			32'sd611883, 32'sd549582, 32'sd383133, 32'sd192774, 32'sd66420};
		return t[dr * 5 + dc];
	endfunction

	// round half up to frac bits (arithmetic shift floors)
	function automatic logic signed [31:0] coef(input int r, input int c, input int frac);
		int dr;
		int dc;
		int sh;
		logic signed [31:0] v;
		dr = (r > Rad) ? r - Rad : Rad - r;
		dc = (c > Rad) ? c - Rad : Rad - c;
		sh = 24 - frac;
		v = log_q24(dr, dc);
		if (sh > 0)
			v = (v + (32'sd1 <<< (sh - 1))) >>> sh;
		return v;
	endfunction
endpackage
`default_nettype wire

@@ sv/mhed_stream_if.sv @@
// Interfaces: input word and result word channels.
`timescale 1ns / 1ps
`default_nettype none
interface mhed_in_if;
	logic valid;
	logic ready;
	logic action;
	logic [7:0] pixel;
	modport source(output valid, action, pixel, input ready);
	modport sink(input valid, action, pixel, output ready);
endinterface

interface mhed_out_if;
	logic valid;
	logic ready;
	logic [7:0] edge_value;
	logic end_of_row;
	logic end_of_frame;
	modport source(output valid, edge_value, end_of_row, end_of_frame, input ready);
	modport sink(input valid, edge_value, end_of_row, end_of_frame, output ready);
endinterface
`default_nettype wire

@@ sv/marr_hildreth_edge_detector.sv @@
// Top level: 9x9 LoG convolution and zero-crossing edge detector.
`timescale 1ns / 1ps
`default_nettype none
// Takes one gray pixel per clock in raster order, unless stalled, and presents result
// words on the output channel; new words enter while earlier ones are still in flight, and
// each result passes the line-store read, the product stage, three adder-tree stages
// (row sums, row groups, total) and the sign stage with its result register.
// The whole pipeline advances together and holds when the output register is full
// and not taken. Eight pixel line memories and two sign line memories hold one row
// each. image_width/image_height writes restart the frame; after the last pixel,
// W-7 drain words flush the remaining border results.
module marr_hildreth_edge_detector #(
	parameter int MAX_WIDTH = 2048,
	parameter int COEF_FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	mhed_in_if.sink in_ch,
	mhed_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [mhed_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [mhed_pkg::CfgDataW-1:0] cfg_data
);
	localparam int Win = mhed_pkg::Win;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int SW = mhed_pkg::SumW;

	logic [11:0] width_q;
	logic [12:0] height_q;
	logic [12:0] row_q;
	logic [XW-1:0] col_q;
	logic [11:0] drain_q;
	logic [XW:0] w_eff;
	logic [12:0] h_eff;
	logic [XW:0] mw;

	always_comb begin
		if (width_q < 12'(Win + 2))
			w_eff = (XW + 1)'(Win + 2);
		else if ({2'b0, width_q} > 14'(MAX_WIDTH))
			w_eff = (XW + 1)'(MAX_WIDTH);
		else
			w_eff = (XW + 1)'(width_q);
		if (height_q < 13'(Win + 2))
			h_eff = 13'(Win + 2);
		else if ({1'b0, height_q} > 14'(mhed_pkg::MaxHeight))
			h_eff = 13'(mhed_pkg::MaxHeight);
		else
			h_eff = height_q;
		mw = w_eff - (XW + 1)'(Win - 1);
	end

	logic adv;
	logic acc;
	logic frame_done;
	logic is_drain;
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;
	assign acc = in_ch.valid && adv;
	assign frame_done = row_q >= h_eff;
	assign is_drain = in_ch.action == mhed_pkg::ACT_DRAIN;

	// position counters and frame control
	logic [12:0] y_cur;
	assign y_cur = (frame_done && !is_drain) ? 13'd0 : row_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= mhed_pkg::WIDTH_RESET;
			height_q <= mhed_pkg::HEIGHT_RESET;
			row_q <= '0;
			col_q <= '0;
			drain_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == mhed_pkg::REG_WIDTH)
				width_q <= cfg_data[11:0];
			else
				height_q <= cfg_data;
			row_q <= '0;
			col_q <= '0;
			drain_q <= '0;
		end else if (acc) begin
			if (is_drain) begin
				if (frame_done) begin
					if ((XW + 1)'(drain_q) >= mw) begin
						row_q <= '0;
						col_q <= '0;
						drain_q <= '0;
					end else
						drain_q <= drain_q + 12'd1;
				end
			end else begin
				if (frame_done)
					drain_q <= '0;
				if ((XW + 1)'(col_q) + 1'b1 >= w_eff) begin
					col_q <= '0;
					row_q <= y_cur + 13'd1;
				end else begin
					col_q <= col_q + 1'b1;
					row_q <= y_cur;
				end
			end
		end
	end

	// stage 1: line store read and write
	logic [2:0] ybank;
	assign ybank = y_cur[2:0];
	logic [7:0] lmem [Win-1][MAX_WIDTH];
	logic [7:0] lrd_s1 [Win-1];
	logic pv_s1;
	logic dv_s1;
	logic [7:0] pix_s1;
	logic [2:0] bank_s1;
	logic [12:0] y_s1;
	logic [XW-1:0] x_s1;
	logic [11:0] d_s1;
	logic [XW:0] mw_s1;

	always_ff @(posedge clk) begin
		if (acc && !is_drain) begin
			for (int k = 0; k < Win - 1; k++) begin
				lrd_s1[k] <= lmem[k][col_q];
				if (3'(k) == ybank)
					lmem[k][col_q] <= in_ch.pixel;
			end
		end
		if (adv) begin
			pix_s1 <= in_ch.pixel;
			bank_s1 <= ybank;
			y_s1 <= y_cur;
			x_s1 <= col_q;
			d_s1 <= drain_q;
			mw_s1 <= mw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			dv_s1 <= 1'b0;
		end else if (cfg_we) begin
			pv_s1 <= 1'b0;
			dv_s1 <= 1'b0;
		end else if (adv) begin
			pv_s1 <= acc && !is_drain;
			dv_s1 <= acc && is_drain && frame_done;
		end
	end

	// pixel window, shifted once per pixel word
	logic [7:0] win_q [Win][Win];
	logic [7:0] newcol [Win];
	always_comb begin
		for (int k = 0; k < Win - 1; k++)
			newcol[k] = lrd_s1[3'(bank_s1 + 3'(k))];
		newcol[Win-1] = pix_s1;
	end

	// stage 2: products, window updated in place of this stage
	localparam int PW = mhed_pkg::ProdW;
	logic signed [PW-1:0] prod_s2 [Win][Win];
	logic v2_s2;
	logic emit_s2;
	logic [7:0] ev_s2;
	logic eor_s2;
	logic eof_s2;
	logic pix_s2;
	logic [12:0] y_s2;
	logic [XW-1:0] x_s2;
	logic win_ok_s1;
	assign win_ok_s1 = y_s1 >= 13'(Win - 1) && x_s1 >= XW'(Win - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < Win; r++)
				for (int c = 0; c < Win; c++)
					win_q[r][c] <= '0;
		end else if (adv && pv_s1) begin
			for (int r = 0; r < Win; r++) begin
				for (int c = 0; c < Win - 1; c++)
					win_q[r][c] <= win_q[r][c+1];
				win_q[r][Win-1] <= newcol[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < Win; r++)
				for (int c = 0; c < Win; c++)
					prod_s2[r][c] <= $signed({1'b0, (c == Win - 1) ? newcol[r] : win_q[r][c+1]})
						* PW'(mhed_pkg::coef(r, c, COEF_FRAC_BITS));
			ev_s2 <= '0;
			eor_s2 <= (d_s1 == '0) || ((XW + 1)'(d_s1) == mw_s1);
			eof_s2 <= (XW + 1)'(d_s1) == mw_s1;
			y_s2 <= y_s1 - 13'(Win - 1);
			x_s2 <= x_s1 - XW'(Win - 1);
			pix_s2 <= pv_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
			emit_s2 <= 1'b0;
		end else if (cfg_we) begin
			v2_s2 <= 1'b0;
			emit_s2 <= 1'b0;
		end else if (adv) begin
			v2_s2 <= (pv_s1 && win_ok_s1) || dv_s1;
			emit_s2 <= dv_s1;
		end
	end

	// stages 3..5: adder tree (rows, then three, then total)
	logic signed [SW-1:0] rs_n [Win];
	logic signed [SW-1:0] rs_s3 [Win];
	logic signed [SW-1:0] gs_s4 [3];
	logic signed [SW-1:0] tot_s5;
	logic [2:0] vv_q;
	logic [2:0] dr_q;
	logic [7:0] ev_q [3];
	logic eor_q [3];
	logic eof_q [3];
	logic [12:0] y_q [3];
	logic [XW-1:0] x_q [3];
	logic [2:0] pp_q;

	always_comb begin
		for (int r = 0; r < Win; r++) begin
			rs_n[r] = '0;
			for (int c = 0; c < Win; c++)
				rs_n[r] = rs_n[r] + SW'(prod_s2[r][c]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < Win; r++)
				rs_s3[r] <= rs_n[r];
			for (int g = 0; g < 3; g++)
				gs_s4[g] <= rs_s3[3*g] + rs_s3[3*g+1] + rs_s3[3*g+2];
			tot_s5 <= gs_s4[0] + gs_s4[1] + gs_s4[2];
			ev_q[0] <= ev_s2;
			eor_q[0] <= eor_s2;
			eof_q[0] <= eof_s2;
			y_q[0] <= y_s2;
			x_q[0] <= x_s2;
			pp_q[0] <= pix_s2;
			for (int i = 1; i < 3; i++) begin
				ev_q[i] <= ev_q[i-1];
				eor_q[i] <= eor_q[i-1];
				eof_q[i] <= eof_q[i-1];
				y_q[i] <= y_q[i-1];
				x_q[i] <= x_q[i-1];
				pp_q[i] <= pp_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv_q <= '0;
			dr_q <= '0;
		end else if (cfg_we) begin
			vv_q <= '0;
			dr_q <= '0;
		end else if (adv) begin
			vv_q <= {vv_q[1:0], v2_s2};
			dr_q <= {dr_q[1:0], emit_s2};
		end
	end

	// stage 6: sign window and line stores, result register
	logic [1:0] s_cur;
	assign s_cur = (tot_s5 > 0) ? mhed_pkg::SIGN_POS
		: ((tot_s5 < 0) ? mhed_pkg::SIGN_NEG : mhed_pkg::SIGN_ZERO);
	logic [1:0] smem [2][MAX_WIDTH];
	logic [1:0] sw_q [3][3];
	logic [1:0] sa_s5;
	logic [1:0] sb_s5;
	logic [12:0] ly;
	logic [XW-1:0] lx;
	assign ly = y_q[2];
	assign lx = x_q[2];

	// sign line store read one stage ahead, alongside the total
	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s5 <= smem[y_q[1][0]][x_q[1]];
			sb_s5 <= smem[!y_q[1][0]][x_q[1]];
		end
	end

	logic [1:0] nw [3][3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nw[r][0] = sw_q[r][1];
			nw[r][1] = sw_q[r][2];
		end
		nw[0][2] = sa_s5;
		nw[1][2] = sb_s5;
		nw[2][2] = s_cur;
	end

	logic zc;
	assign zc = ((nw[0][1] ^ nw[2][1]) == 2'b11) || ((nw[1][0] ^ nw[1][2]) == 2'b11)
		|| ((nw[2][0] ^ nw[0][2]) == 2'b11) || ((nw[0][0] ^ nw[2][2]) == 2'b11);

	logic sig_v;
	assign sig_v = vv_q[2] && pp_q[2];

	always_ff @(posedge clk) begin
		if (adv && sig_v)
			smem[ly[0]][lx] <= s_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					sw_q[r][c] <= mhed_pkg::SIGN_ZERO;
			out_ch.valid <= 1'b0;
			out_ch.edge_value <= '0;
			out_ch.end_of_row <= 1'b0;
			out_ch.end_of_frame <= 1'b0;
		end else begin
			if (adv && sig_v)
				sw_q <= nw;
			if (cfg_we)
				out_ch.valid <= 1'b0;
			else if (adv) begin
				out_ch.valid <= 1'b0;
				if (vv_q[2] && dr_q[2]) begin
					out_ch.valid <= 1'b1;
					out_ch.edge_value <= ev_q[2];
					out_ch.end_of_row <= eor_q[2];
					out_ch.end_of_frame <= eof_q[2];
				end else if (sig_v) begin
					out_ch.edge_value <= '0;
					out_ch.end_of_row <= 1'b0;
					out_ch.end_of_frame <= 1'b0;
					if (lx == '0) begin
						out_ch.valid <= ly >= 13'd2;
						out_ch.end_of_row <= 1'b1;
					end else if (ly != '0) begin
						out_ch.valid <= 1'b1;
						if (ly >= 13'd2 && lx >= XW'(2) && zc)
							out_ch.edge_value <= 8'd255;
					end
				end
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready && !cfg_we |=> out_ch.valid)
		else $error("result word dropped while stalled");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !in_ch.ready)
		else $error("input taken during stall");
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.end_of_frame |-> out_ch.end_of_row && out_ch.edge_value == 8'd0)
		else $error("frame end without row end");
endmodule
`default_nettype wire
